// ----- src/gbz_pkg.sv -----
`default_nettype none

package gbz_pkg;

    // register and field widths
    localparam int CFG_W   = 12;
    localparam int PIX_W   = 8;
    localparam int COORD_W = 12;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    // sum / 3 as (sum * 683) >> 11, exact for sums up to 765
    localparam int SUM_W       = 10;
    localparam int PROD_W      = 20;
    localparam int GREY_RECIP  = 683;
    localparam int GREY_SHIFT  = 11;

    // bit positions in the pending result mask, in emission order
    localparam int RES_LEFT   = 0;
    localparam int RES_CENTER = 1;
    localparam int RES_DIAG   = 2;
    localparam int RES_UP     = 3;
    localparam int RES_N      = 4;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    function automatic logic [PIX_W-1:0] grey_of(
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] r
    );
        logic [SUM_W-1:0]  sum;
        logic [PROD_W-1:0] prod;
        sum  = SUM_W'(b) + SUM_W'(g) + SUM_W'(r);
        prod = PROD_W'(sum) * PROD_W'(GREY_RECIP);
        return prod[GREY_SHIFT+PIX_W-1:GREY_SHIFT];
    endfunction

endpackage

`default_nettype wire

// ----- src/gbz_ram.sv -----
`default_nettype none

module gbz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read and a write to the same entry return the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/grey_bilinear_zoom_2x.sv -----
// channel   direction  handshake               payload
// pix       in         pix_valid / pix_ready   blue, green, red
// res       out        res_valid / res_ready   out_row, out_col, grey_value, last_of_run
// apb       in         psel, penable, pready   paddr, pwrite, pwdata, prdata
//
// a pixel enters the result stage at the edge that accepts it; its first word goes from there
// into the output register and onto the result port, and it leaves 1 to 4 words, one per cycle
// while res_ready is not held low, on the single result port; that port sets the rate (4 words
// per pixel from row 1 on, 2 in row 0 or column 0, 1 for the first pixel of a frame)
// the next pixel is accepted in the cycle its predecessor hands over its last word
// reset (rst_n low, asynchronous) clears counters and flags and loads 640 x 480 into the
// size registers; the line buffer is not cleared, its entries are written before they are read
// a stalled res_ready holds the output register and the result stage in place

`default_nettype none

module grey_bilinear_zoom_2x
    import gbz_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic      [APB_DW-1:0]    prdata,
    output logic                      pready,

    input  wire logic                 pix_valid,
    output logic                      pix_ready,
    input  wire logic [PIX_W-1:0]     blue,
    input  wire logic [PIX_W-1:0]     green,
    input  wire logic [PIX_W-1:0]     red,

    output logic                      res_valid,
    input  wire logic                 res_ready,
    output logic      [COORD_W-1:0]   out_row,
    output logic      [COORD_W-1:0]   out_col,
    output logic      [PIX_W-1:0]     grey_value,
    output logic                      last_of_run
);

    // counter widths and compare widths for the clamped sizes
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int WCMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int HCMP_W = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // effective sizes: zero acts as one, anything above the maximum as the maximum
    logic [WCMP_W-1:0] width_eff;
    logic [HCMP_W-1:0] height_eff;

    always_comb
    begin
        if (width_reg == '0)
            width_eff = WCMP_W'(1);
        else if (WCMP_W'(width_reg) > WCMP_W'(MAX_WIDTH))
            width_eff = WCMP_W'(MAX_WIDTH);
        else
            width_eff = WCMP_W'(width_reg);

        if (height_reg == '0)
            height_eff = HCMP_W'(1);
        else if (HCMP_W'(height_reg) > HCMP_W'(MAX_HEIGHT))
            height_eff = HCMP_W'(MAX_HEIGHT);
        else
            height_eff = HCMP_W'(height_reg);
    end

    // ---------------------------------------------------------------
    // input side: grey conversion, raster counters, line buffer access
    // ---------------------------------------------------------------
    logic             pix_acc;
    logic [PIX_W-1:0] pix_grey;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PIX_W-1:0] prev_grey_reg;
    logic             col_wrap;
    logic             row_wrap;
    logic [PIX_W-1:0] above_rd;

    assign pix_acc  = pix_valid & pix_ready;
    assign pix_grey = grey_of(blue, green, red);
    assign col_wrap = (WCMP_W'(col_reg) + WCMP_W'(1)) >= width_eff;
    assign row_wrap = (HCMP_W'(row_reg) + HCMP_W'(1)) >= height_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            prev_grey_reg <= '0;
        end
        else if (pix_acc)
        begin
            prev_grey_reg <= pix_grey;
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // previous grey row; the word above is read and overwritten at the same edge
    gbz_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (pix_acc),
        .waddr (col_reg),
        .wdata (pix_grey),
        .re    (pix_acc),
        .raddr (col_reg),
        .rdata (above_rd)
    );

    // ---------------------------------------------------------------
    // result stage: one pixel, a mask of its pending results
    // ---------------------------------------------------------------
    logic [RES_N-1:0] mask_reg;
    logic [RES_N-1:0] mask_next;
    logic [RES_N-1:0] pick;
    logic [RES_N-1:0] mask_rest;
    logic [PIX_W-1:0] s1_grey_reg;
    logic [PIX_W-1:0] s1_prev_reg;
    logic [PIX_W-1:0] s1_al_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_valid;
    logic             adv;
    logic             res_valid_reg;
    logic             row_nz;
    logic             col_nz;

    assign s1_valid  = |mask_reg;
    assign adv       = s1_valid & (~res_valid_reg | res_ready);
    assign pick      = mask_reg & (~mask_reg + RES_N'(1));
    assign mask_rest = mask_reg & ~pick;
    assign pix_ready = ~s1_valid | (adv & (mask_rest == '0));
    assign row_nz    = (row_reg != '0);
    assign col_nz    = (col_reg != '0);

    always_comb
    begin
        mask_next = mask_reg;
        if (pix_acc)
        begin
            mask_next[RES_LEFT]   = col_nz;
            mask_next[RES_CENTER] = 1'b1;
            mask_next[RES_DIAG]   = row_nz & col_nz;
            mask_next[RES_UP]     = row_nz;
        end
        else if (adv)
        begin
            mask_next = mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    // the line buffer output still holds the previous pixel's word above,
    // which is this pixel's word above and to the left
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_grey_reg <= pix_grey;
            s1_prev_reg <= prev_grey_reg;
            s1_al_reg   <= above_rd;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
        end
    end

    // interpolated values, every average truncates
    logic [PIX_W:0]   sum_left;
    logic [PIX_W:0]   sum_upmid;
    logic [PIX_W:0]   sum_diag;
    logic [PIX_W:0]   sum_up;
    logic [PIX_W-1:0] left_mid;
    logic [PIX_W-1:0] up_mid;
    logic [PIX_W-1:0] diag_val;
    logic [PIX_W-1:0] up_val;

    assign sum_left  = {1'b0, s1_prev_reg} + {1'b0, s1_grey_reg};
    assign left_mid  = sum_left[PIX_W:1];
    assign sum_upmid = {1'b0, s1_al_reg} + {1'b0, above_rd};
    assign up_mid    = sum_upmid[PIX_W:1];
    assign sum_diag  = {1'b0, up_mid} + {1'b0, left_mid};
    assign diag_val  = sum_diag[PIX_W:1];
    assign sum_up    = {1'b0, above_rd} + {1'b0, s1_grey_reg};
    assign up_val    = sum_up[PIX_W:1];

    // zoomed coordinates
    logic [ROW_W:0] row2;
    logic [ROW_W:0] row2m1;
    logic [COL_W:0] col2;
    logic [COL_W:0] col2m1;

    assign row2   = {s1_row_reg, 1'b0};
    assign row2m1 = row2 - (ROW_W + 1)'(1);
    assign col2   = {s1_col_reg, 1'b0};
    assign col2m1 = col2 - (COL_W + 1)'(1);

    logic [COORD_W-1:0] sel_row;
    logic [COORD_W-1:0] sel_col;
    logic [PIX_W-1:0]   sel_grey;

    always_comb
    begin
        if (pick[RES_LEFT])
        begin
            sel_row  = COORD_W'(row2);
            sel_col  = COORD_W'(col2m1);
            sel_grey = left_mid;
        end
        else if (pick[RES_CENTER])
        begin
            sel_row  = COORD_W'(row2);
            sel_col  = COORD_W'(col2);
            sel_grey = s1_grey_reg;
        end
        else if (pick[RES_DIAG])
        begin
            sel_row  = COORD_W'(row2m1);
            sel_col  = COORD_W'(col2m1);
            sel_grey = diag_val;
        end
        else
        begin
            sel_row  = COORD_W'(row2m1);
            sel_col  = COORD_W'(col2);
            sel_grey = up_val;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic [PIX_W-1:0]   grey_value_reg;
    logic               last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_row_reg    <= sel_row;
            out_col_reg    <= sel_col;
            grey_value_reg <= sel_grey;
            last_reg       <= (mask_rest == '0);
        end
    end

    assign res_valid   = res_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign grey_value  = grey_value_reg;
    assign last_of_run = last_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------

    // every accepted pixel owes at least its own center result
    a_center_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc |=> mask_reg[RES_CENTER])
        else $error("accepted pixel has no center result pending");

    // the diagonal result only exists together with the vertical one
    a_diag_needs_up: assert property (@(posedge clk) disable iff (!rst_n)
        mask_reg[RES_DIAG] |-> mask_reg[RES_UP])
        else $error("diagonal result pending without vertical result");

    // a new pixel never enters while the current one still has work left
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_acc && s1_valid) |-> (adv && (mask_rest == '0)))
        else $error("pixel accepted over unfinished results");

    // the column counter stays inside the line buffer
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (COL_W + 1)'(col_reg) < (COL_W + 1)'(MAX_WIDTH))
        else $error("column counter beyond line buffer");

endmodule

`default_nettype wire

// ----- sim/gbz_zoom_check.sv -----
module gbz_zoom_check
    import gbz_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,

    input  logic                 pix_valid,
    input  logic                 pix_ready,
    input  logic [PIX_W-1:0]     blue,
    input  logic [PIX_W-1:0]     green,
    input  logic [PIX_W-1:0]     red,

    input  logic                 res_valid,
    input  logic                 res_ready,
    input  logic [COORD_W-1:0]   out_row,
    input  logic [COORD_W-1:0]   out_col,
    input  logic [PIX_W-1:0]     grey_value,
    input  logic                 last_of_run,

    output int                   mismatches,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   grey;
        logic               last;
    } zoom_word_t;

    zoom_word_t       zoom_q[$];
    bit   [PIX_W-1:0] row_above [MAX_WIDTH];
    bit   [PIX_W-1:0] left_grey;
    bit   [PIX_W-1:0] diag_grey;
    int               row_idx;
    int               col_idx;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int               fails;

    // register value as the block uses it
    function automatic int effective(input logic [CFG_W-1:0] v, input int max);
        if (v == '0)
            return 1;
        if (int'(v) > max)
            return max;
        return int'(v);
    endfunction

    function automatic zoom_word_t word_at(input int row, input int col, input int grey);
        zoom_word_t w;
        w.row  = COORD_W'(row);
        w.col  = COORD_W'(col);
        w.grey = PIX_W'(grey);
        w.last = 1'b0;
        return w;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            fails++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        zoom_word_t want;
        int         grey;
        int         above;
        int         left_mid;
        int         jx;
        if (!rst_n)
        begin
            zoom_q.delete();
            left_grey  = '0;
            diag_grey  = '0;
            row_idx    = 0;
            col_idx    = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            fails      = 0;
            pending    <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_AW-1:2]))
                    REG_WIDTH:  width_reg  = pwdata[CFG_W-1:0];
                    REG_HEIGHT: height_reg = pwdata[CFG_W-1:0];
                    default:    ;
                endcase
            end

            // one pixel in, up to four words out
            if (pix_valid && pix_ready)
            begin
                grey     = (int'(blue) + int'(green) + int'(red)) / 3;
                jx       = (col_idx < MAX_WIDTH) ? col_idx : MAX_WIDTH - 1;
                above    = int'(row_above[jx]);
                left_mid = (int'(left_grey) + grey) / 2;
                if (col_idx > 0)
                    zoom_q.push_back(word_at(2 * row_idx, 2 * col_idx - 1, left_mid));
                zoom_q.push_back(word_at(2 * row_idx, 2 * col_idx, grey));
                if (row_idx > 0 && col_idx > 0)
                    zoom_q.push_back(word_at(2 * row_idx - 1, 2 * col_idx - 1,
                                             ((int'(diag_grey) + above) / 2 + left_mid) / 2));
                if (row_idx > 0)
                    zoom_q.push_back(word_at(2 * row_idx - 1, 2 * col_idx, (above + grey) / 2));
                zoom_q[zoom_q.size() - 1].last = 1'b1;

                diag_grey     = PIX_W'(above);
                row_above[jx] = PIX_W'(grey);
                left_grey     = PIX_W'(grey);

                if (col_idx + 1 >= effective(width_reg, MAX_WIDTH))
                begin
                    col_idx = 0;
                    row_idx = (row_idx + 1 >= effective(height_reg, MAX_HEIGHT)) ?
                              0 : row_idx + 1;
                end
                else
                    col_idx++;
            end

            if (res_valid && res_ready)
            begin
                if (zoom_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: word with nothing expected: row %0d col %0d grey %0d last %0b",
                             $time, out_row, out_col, grey_value, last_of_run);
                end
                else
                begin
                    want = zoom_q.pop_front();
                    compare_field("out_row", want.row, out_row);
                    compare_field("out_col", want.col, out_col);
                    compare_field("grey_value", want.grey, grey_value);
                    compare_field("last_of_run", want.last, last_of_run);
                end
            end

            pending    <= zoom_q.size();
            mismatches <= fails;
        end
    end

endmodule

// ----- sim/testbench.sv -----
module testbench;
    import gbz_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH      = 2048;
    localparam int MAX_HEIGHT     = 2048;
    localparam int RANDOM_ITEMS   = 120;
    localparam int LONG_HOLD      = 80;     // receiver hold-off, long enough to fill the block
    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no word moving on any port
    localparam int DRAIN_TAIL     = 16;

    // corner patterns for the small directed frame, {blue, green, red}
    localparam logic [12*24-1:0] CORNER_RGB = {
        24'hFFFFFF, 24'h000000, 24'hFFFFFE, 24'h030000,
        24'h000000, 24'hFFFFFF, 24'h010101, 24'hFFFFFF,
        24'h808080, 24'h000000, 24'hFFFEFF, 24'h020000
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;

    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [APB_AW-1:0]    paddr     = '0;
    logic [APB_DW-1:0]    pwdata    = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    logic                 pix_valid = 1'b0;
    logic                 pix_ready;
    logic [PIX_W-1:0]     blue      = '0;
    logic [PIX_W-1:0]     green     = '0;
    logic [PIX_W-1:0]     red       = '0;

    logic                 res_valid;
    logic                 res_ready = 1'b0;
    logic [COORD_W-1:0]   out_row;
    logic [COORD_W-1:0]   out_col;
    logic [PIX_W-1:0]     grey_value;
    logic                 last_of_run;

    int                   mismatches;
    int                   pending;

    // stimulus bookkeeping: where the next pixel lands and the sizes in force
    int                   col_pos = 0;
    int                   row_pos = 0;
    int                   eff_w   = 640;
    int                   eff_h   = 480;
    int                   pixels_sent = 0;
    int                   quiet_cycles = 0;
    bit                   src_steady = 1'b0;   // sender offers back to back
    bit                   hold_req   = 1'b0;   // asks the receiver for a long hold-off

    always #2 clk = ~clk;

    grey_bilinear_zoom_2x #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .grey_value  (grey_value),
        .last_of_run (last_of_run)
    );

    gbz_zoom_check #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) zoom_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .out_row     (out_row),
        .out_col     (out_col),
        .grey_value  (grey_value),
        .last_of_run (last_of_run),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // size register value as the block applies it
    function automatic int dim_of(input logic [CFG_W-1:0] v, input int max);
        if (v == '0)
            return 1;
        if (int'(v) > max)
            return max;
        return int'(v);
    endfunction

    function automatic logic [CFG_W-1:0] small_dim(input int top);
        return CFG_W'($urandom_range(0, top));
    endfunction

    // exactly the maximum, or above it where the block clips
    function automatic logic [CFG_W-1:0] large_dim();
        if ($urandom_range(0, 1) == 0)
            return CFG_W'(2048);
        return CFG_W'($urandom_range(2049, 4095));
    endfunction

    // offer one pixel word and hold it until taken
    task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] r);
        int gap;
        gap = src_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        blue      <= b;
        green     <= g;
        red       <= r;
        do
            @(posedge clk);
        while (!pix_ready);
        pixels_sent++;
        // track the raster position, including a row or frame cut short by a resize
        if (col_pos + 1 >= eff_w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= eff_h) ? 0 : row_pos + 1;
        end
        else
            col_pos++;
    endtask

    task automatic send_random_pixel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            send_pixel(8'hFF, 8'hFF, 8'hFF);
        else if (pick == 1)
            send_pixel(8'h00, 8'h00, 8'h00);
        else
            send_pixel(PIX_W'($urandom()), PIX_W'($urandom()), PIX_W'($urandom()));
    endtask

    // stop offering and wait until every expected word has come out
    task automatic drain();
        pix_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // withdraw the last word, then ask the receiver for a long hold-off
    task automatic long_hold();
        pix_valid <= 1'b0;
        @(posedge clk);
        src_steady = 1'b1;
        hold_req   = 1'b1;
        wait (!hold_req);
    endtask

    // setup then access phase; junk above the 12 register bits
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= {(APB_DW - CFG_W)'($urandom()), v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // new image size; a wider row only starts at a frame boundary so that the
    // line buffer is always filled before it is read
    task automatic resize(input logic [CFG_W-1:0] w_reg, input logic [CFG_W-1:0] h_reg);
        int new_w;
        int new_h;
        new_w = dim_of(w_reg, MAX_WIDTH);
        new_h = dim_of(h_reg, MAX_HEIGHT);
        if (new_w > eff_w)
            while (col_pos != 0 || row_pos != 0)
                send_random_pixel();
        drain();
        write_reg(REG_WIDTH, w_reg);
        write_reg(REG_HEIGHT, h_reg);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        eff_w = new_w;
        eff_h = new_h;
    endtask

    // receiver: random stalls, steady stretches, and a long hold-off on request
    initial
    begin : sink
        int gap;
        bit steady;
        @(posedge clk);
        forever
        begin
            steady = ($urandom_range(0, 7) == 0);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                gap = steady ? 0 : idle_len();
                if (gap > 0)
                begin
                    res_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            res_ready <= 1'b1;
            repeat (steady ? $urandom_range(40, 80) : $urandom_range(1, 12)) @(posedge clk);
        end
    end

    // watchdog: ends the run when no word moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && pix_ready) || (res_valid && res_ready) ||
            (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("grey_bilinear_zoom_2x test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int base;
        int area;
        logic [23:0] rgb;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // two pixels at the reset size, darkest and brightest
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);

        // width register 0 acts as 1 and cuts the current row short
        resize(CFG_W'(0), CFG_W'(480));
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'hFF);

        // height shrunk below the current row: the frame wraps after this row
        resize(CFG_W'(0), CFG_W'(2));
        send_pixel(8'h03, 8'h00, 8'h00);
        send_pixel(8'hFE, 8'hFF, 8'hFF);

        // small frame of corners and odd sums, every output kind and truncation
        resize(CFG_W'(4), CFG_W'(3));
        for (int k = 0; k < 12; k++)
        begin
            rgb = CORNER_RGB[(11 - k) * 24 +: 24];
            send_pixel(rgb[23:16], rgb[15:8], rgb[7:0]);
        end

        // long receiver hold-off while words keep coming, so the input stalls
        base = pixels_sent;
        long_hold();
        repeat (20) send_random_pixel();

        while (pixels_sent - base < RANDOM_ITEMS)
        begin
            src_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                6, 7:
                begin
                    // resize mid-frame: row no wider than now, height up to 5
                    resize(CFG_W'($urandom_range(0, eff_w)), small_dim(5));
                    repeat ($urandom_range(1, 8)) send_random_pixel();
                end
                8:
                begin
                    long_hold();
                    repeat (12) send_random_pixel();
                end
                9:
                begin
                    // one size at its maximum for a few pixels, then back to small
                    if ($urandom_range(0, 1) == 0)
                        resize(large_dim(), small_dim(3));
                    else
                        resize(small_dim(4), large_dim());
                    repeat ($urandom_range(6, 15)) send_random_pixel();
                    resize(CFG_W'($urandom_range(0, (eff_w < 4) ? eff_w : 4)), small_dim(4));
                end
                default:
                begin
                    // whole small frames and a bit of the next
                    resize(small_dim(6), small_dim(5));
                    area = eff_w * eff_h;
                    repeat (area + $urandom_range(0, area + 2)) send_random_pixel();
                end
            endcase
        end

        drain();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("grey_bilinear_zoom_2x test passed");
        else
            $display("grey_bilinear_zoom_2x test failed");
        $finish;
    end

endmodule
